/* design/srte_pkg.sv */
// Shared types, codes and level-update functions for the rule table evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package srte_pkg;

    // Field widths
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 8;
    localparam int DEPTH_W   = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ADDR_HI = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ADDR_LO = 8'd1;

    // Entry kinds
    localparam logic [2:0] KIND_ALL    = 3'd0;
    localparam logic [2:0] KIND_EXISTS = 3'd1;
    localparam logic [2:0] KIND_IP4    = 3'd2;
    localparam logic [2:0] KIND_IP6    = 3'd3;
    localparam logic [2:0] KIND_BEGIN  = 3'd4;
    localparam logic [2:0] KIND_END    = 3'd5;

    // Qualifiers
    localparam logic [2:0] QUAL_NONE     = 3'd0;
    localparam logic [2:0] QUAL_PASS     = 3'd1;
    localparam logic [2:0] QUAL_FAIL     = 3'd2;
    localparam logic [2:0] QUAL_SOFTFAIL = 3'd3;
    localparam logic [2:0] QUAL_NEUTRAL  = 3'd4;

    // Level results
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_PASS = 2'd1;
    localparam logic [1:0] RES_FAIL = 2'd2;

    // One nesting level: 7 bits
    typedef struct packed {
        logic [1:0] res;
        logic       bias;
        logic       all;
        logic [2:0] qual;
    } level_t;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_MATCH = 2'd1,
        OP_BEGIN = 2'd2,
        OP_END   = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t   op;
        logic       matched;
        logic       is_all;
        logic [2:0] qual;
        logic       redir;
        logic       last;
    } op_t;

    // First match decides; fail on an all entry only at top level or in a redirect
    function automatic level_t apply_match(level_t lv, logic matched, logic [2:0] q,
                                           logic is_all, logic is_top);
        level_t r;
        r = lv;
        if (lv.res == RES_NONE && matched) begin
            case (q)
                QUAL_SOFTFAIL: r.bias = 1'b1;
                QUAL_NEUTRAL:  r = lv;
                QUAL_FAIL: begin
                    if (!is_all || is_top || lv.all) begin
                        r.res = RES_FAIL;
                    end
                end
                default: r.res = RES_PASS;
            endcase
        end
        return r;
    endfunction

    function automatic logic [2:0] invert_qual(logic [2:0] q);
        logic [2:0] r;
        case (q)
            QUAL_PASS:     r = QUAL_FAIL;
            QUAL_FAIL:     r = QUAL_PASS;
            QUAL_SOFTFAIL: r = QUAL_NEUTRAL;
            QUAL_NEUTRAL:  r = QUAL_NEUTRAL;
            default:       r = QUAL_NONE;
        endcase
        return r;
    endfunction

    // Fold a closed child level's result into its parent
    function automatic level_t apply_nested(level_t parent, logic [1:0] res, logic [2:0] q);
        level_t r;
        logic [2:0] qq;
        r  = parent;
        qq = (res == RES_FAIL) ? invert_qual(q) : q;
        if (res != RES_NONE) begin
            r = apply_match(parent, 1'b1, qq, 1'b0, 1'b0);
        end
        return r;
    endfunction

    // Result of a level that runs out of entries: bias alone becomes fail
    function automatic logic [1:0] finish_exhausted(level_t lv);
        logic [1:0] r;
        r = (lv.res == RES_NONE && lv.bias) ? RES_FAIL : lv.res;
        return r;
    endfunction

endpackage

/* design/srte_front.sv */
// Front end: holds the client address and classifies each rule entry.
// Depends on srte_pkg; feeds srte_queue.
`timescale 1ns / 1ps

module srte_front
    import srte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    input  logic [2:0]            kind,
    input  logic [2:0]            qualifier,
    input  logic                  exists_hit,
    input  logic                  is_redirect,
    input  logic [ADDR_W-1:0]     net_hi,
    input  logic [ADDR_W-1:0]     net_lo,
    input  logic [7:0]            prefix_len,
    input  logic                  last,
    output op_t                   op_word
);

    logic [ADDR_W-1:0] client_hi_reg;
    logic [ADDR_W-1:0] client_lo_reg;
    logic [ADDR_W-1:0] mask_hi;
    logic [ADDR_W-1:0] mask_lo;
    logic              net_hit;

    // Client address registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_hi_reg <= '0;
            client_lo_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_CLIENT_ADDR_HI) begin
                client_hi_reg <= cfg_data;
            end else if (cfg_index == REG_CLIENT_ADDR_LO) begin
                client_lo_reg <= cfg_data;
            end
        end
    end

    // Prefix masks, MSB first; lengths above 128 cover every bit
    always_comb begin
        for (int i = 0; i < ADDR_W; i++) begin
            mask_hi[ADDR_W-1-i] = (prefix_len > 8'(i));
            mask_lo[ADDR_W-1-i] = (prefix_len > 8'(i + ADDR_W));
        end
    end

    assign net_hit = (((client_hi_reg ^ net_hi) & mask_hi) == '0) &&
                     (((client_lo_reg ^ net_lo) & mask_lo) == '0);

    // Classify the entry
    always_comb begin
        op_word.qual    = qualifier;
        op_word.redir   = is_redirect;
        op_word.last    = last;
        op_word.is_all  = 1'b0;
        op_word.matched = 1'b0;
        case (kind)
            KIND_ALL: begin
                op_word.op      = OP_MATCH;
                op_word.is_all  = 1'b1;
                op_word.matched = 1'b1;
            end
            KIND_EXISTS: begin
                op_word.op      = OP_MATCH;
                op_word.matched = exists_hit;
            end
            KIND_IP4, KIND_IP6: begin
                op_word.op      = OP_MATCH;
                op_word.matched = net_hit;
            end
            KIND_BEGIN: op_word.op = OP_BEGIN;
            KIND_END:   op_word.op = OP_END;
            default:    op_word.op = OP_NONE;
        endcase
    end

endmodule

/* design/srte_queue.sv */
// Short queue of classified words between front and back.
// Depends on srte_pkg for the word type.
`timescale 1ns / 1ps

module srte_queue
    import srte_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_word,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_word
);

    localparam int QDEPTH = 4;
    localparam int PTR_W  = 2;

    op_t            mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 3'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_word  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QDEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a write");
`endif

endmodule

/* design/srte_back.sv */
// Back end: nesting-level stack, per-entry evaluation, unwind sequencer and result register.
// Depends on srte_pkg; consumes words from srte_queue.
`timescale 1ns / 1ps

module srte_back
    import srte_pkg::*;
#(
    parameter int MAX_NEST = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  op_t        q_word,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] res_verdict,
    output logic       res_overflow
);

    localparam int STK_N = MAX_NEST - 1;
    localparam logic [DEPTH_W-1:0] NEST_D = DEPTH_W'(MAX_NEST);
    localparam logic [DEPTH_W-1:0] TOP_D  = DEPTH_W'(MAX_NEST - 1);

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_UNWIND = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    level_t             cur_reg, cur_next;          // level at the current depth
    level_t             stk_reg [STK_N];            // levels below, nearest first
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               fixed_reg, fixed_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg;
    logic [1:0]         out_verdict_reg;
    logic               out_ovf_reg;
    logic               push, pop, emit;
    logic [DEPTH_W-1:0] eff_depth;
    logic               take;
    logic               out_free;

    assign q_ready   = (state_reg == ST_RUN);
    assign take      = q_valid && q_ready;
    assign out_free  = !out_valid_reg || res_ready;
    assign eff_depth = (depth_reg >= NEST_D) ? TOP_D : depth_reg;

    // Entry evaluation and unwind control
    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        depth_next = depth_reg;
        fixed_next = fixed_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        pop        = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                if (take) begin
                    if (!fixed_reg) begin
                        if (depth_reg >= NEST_D) begin
                            // inside levels that did not fit: only count depth
                            if (q_word.op == OP_BEGIN && depth_reg != '1) begin
                                depth_next = depth_reg + 1'b1;
                            end else if (q_word.op == OP_END) begin
                                depth_next = depth_reg - 1'b1;
                            end
                        end else begin
                            case (q_word.op)
                                OP_MATCH: cur_next = apply_match(cur_reg, q_word.matched,
                                                                 q_word.qual, q_word.is_all,
                                                                 depth_reg == '0);
                                OP_BEGIN: begin
                                    if (depth_reg + 1'b1 < NEST_D) begin
                                        push       = 1'b1;
                                        depth_next = depth_reg + 1'b1;
                                        cur_next   = '{res: RES_NONE, bias: 1'b0,
                                                       all: q_word.redir, qual: q_word.qual};
                                    end else begin
                                        ovf_next   = 1'b1;
                                        depth_next = NEST_D;
                                    end
                                end
                                OP_END: begin
                                    if (depth_reg == '0) begin
                                        fixed_next = 1'b1;
                                    end else begin
                                        pop        = 1'b1;
                                        depth_next = depth_reg - 1'b1;
                                        cur_next   = apply_nested(stk_reg[0], cur_reg.res,
                                                                  cur_reg.qual);
                                    end
                                end
                                default: cur_next = cur_reg;
                            endcase
                        end
                    end
                    if (q_word.last) begin
                        state_next = ST_UNWIND;
                    end
                end
            end
            ST_UNWIND: begin
                if (eff_depth != '0) begin
                    // close one exhausted level per cycle
                    pop        = 1'b1;
                    depth_next = eff_depth - 1'b1;
                    cur_next   = apply_nested(stk_reg[0], finish_exhausted(cur_reg),
                                              cur_reg.qual);
                end else if (out_free) begin
                    emit       = 1'b1;
                    cur_next   = '0;
                    depth_next = '0;
                    fixed_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            cur_reg   <= '0;
            depth_reg <= '0;
            fixed_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            depth_reg <= depth_next;
            fixed_reg <= fixed_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Level stack as a shift line: push moves down, pop moves up
    always_ff @(posedge aclk) begin
        if (push) begin
            stk_reg[0] <= cur_reg;
            for (int i = 1; i < STK_N; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < STK_N - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_verdict_reg <= fixed_reg ? cur_reg.res : finish_exhausted(cur_reg);
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_verdict  = out_verdict_reg;
    assign res_overflow = out_ovf_reg;

`ifndef SYNTHESIS
    a_fixed_top: assert property (@(posedge aclk) disable iff (!aresetn)
        fixed_reg |-> (depth_reg == '0))
        else $error("verdict fixed below the outermost level");
    a_emit_from_unwind: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UNWIND))
        else $error("result loaded outside unwind");
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (state_reg == ST_RUN && depth_reg == '0 && !ovf_reg && !fixed_reg))
        else $error("evaluation state not cleared after result");
`endif

endmodule

/* design/spf_rule_table_evaluator_core.sv */
// Rule table evaluator, top level: one word per cycle into the queue while it has room; a
// result only on the last. The last word passes the queue, then the back end unwinds each
// open level in turn and loads the result register once it is free. Throughput: one rule
// word per cycle while the back end runs; the last word holds it until the result is loaded.
// Reset (aresetn low, synchronous) clears the client address, the level state and the queue.
// Depends on srte_pkg, srte_front, srte_queue and srte_back.
`timescale 1ns / 1ps

module spf_rule_table_evaluator_core
    import srte_pkg::*;
#(
    parameter int MAX_NEST = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // rule entries
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: qualifier[2:0], exists_hit[3], is_redirect[4], net_hi[68:5],
    //        net_lo[132:69], prefix_len[140:133], zero fill[143:141]
    input  logic [143:0]         s_tdata,
    // tuser: kind[2:0]
    input  logic [2:0]           s_tuser,
    input  logic                 s_tlast,
    // verdict words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: verdict[1:0], overflow[2], zero fill[7:3]
    output logic [7:0]           m_tdata
);

    op_t        front_word;
    op_t        back_word;
    logic       q_valid;
    logic       q_ready;
    logic [1:0] verdict;
    logic       overflow;

    assign cfg_ready = 1'b1;

    srte_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (s_tuser),
        .qualifier   (s_tdata[2:0]),
        .exists_hit  (s_tdata[3]),
        .is_redirect (s_tdata[4]),
        .net_hi      (s_tdata[68:5]),
        .net_lo      (s_tdata[132:69]),
        .prefix_len  (s_tdata[140:133]),
        .last        (s_tlast),
        .op_word     (front_word)
    );

    srte_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_word  (front_word),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_word  (back_word)
    );

    srte_back #(
        .MAX_NEST (MAX_NEST)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_word       (back_word),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_verdict  (verdict),
        .res_overflow (overflow)
    );

    assign m_tdata = {5'b0, overflow, verdict};

endmodule

/* tb/sv/spf_rule_table_evaluator_core_test.sv */
// Self-checking testbench for spf_rule_table_evaluator_core: drives rule lists, predicts
// the verdict word of each list and compares it with the block's output.
// Depends on srte_pkg and the spf_rule_table_evaluator_core RTL.
`timescale 1ns / 1ps

import srte_pkg::*;

// One rule entry as the sender sees it
typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  qual;
    logic        hit;
    logic        redir;
    logic [63:0] net_hi;
    logic [63:0] net_lo;
    logic [7:0]  plen;
    logic        last;
} rule_t;

// One verdict word as the receiver sees it
typedef struct packed {
    logic [1:0] verdict;
    logic       overflow;
} verdict_t;

localparam int NEST_LEVELS = 16;

// Verdict predictor plus the store of verdicts still owed by the block
class spf_verdict_board;
    logic [63:0]    addr_hi;
    logic [63:0]    addr_lo;
    level_t         levels[NEST_LEVELS];
    int unsigned    depth;
    bit             end_seen;
    bit             nest_overflow;
    verdict_t       owed_verdicts[$];
    int             mismatches;

    function new();
        addr_hi    = '0;
        addr_lo    = '0;
        mismatches = 0;
        clear_list();
    endfunction

    function void clear_list();
        for (int i = 0; i < NEST_LEVELS; i++) begin
            levels[i] = '0;
        end
        depth         = 0;
        end_seen      = 1'b0;
        nest_overflow = 1'b0;
    endfunction

    function void set_client_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        if (idx == REG_CLIENT_ADDR_HI) begin
            addr_hi = val;
        end else if (idx == REG_CLIENT_ADDR_LO) begin
            addr_lo = val;
        end
    endfunction

    function int pending();
        return owed_verdicts.size();
    endfunction

    // Prefix is clipped to 128; mask covers the top plen bits
    function bit net_hit(logic [63:0] nh, logic [63:0] nl, logic [7:0] plen);
        logic [127:0] mask;
        int           p;
        p    = (plen > 128) ? 128 : int'(plen);
        mask = ~({128{1'b1}} >> p);
        return ((({addr_hi, addr_lo} ^ {nh, nl}) & mask) == '0);
    endfunction

    // First decision per level wins; fail on all only at top or under a redirect
    function void match_level(int unsigned d, bit matched, logic [2:0] q, bit is_all);
        level_t lv;
        lv = levels[d];
        if (lv.res != RES_NONE || !matched) begin
            return;
        end
        case (q)
            QUAL_SOFTFAIL: lv.bias = 1'b1;
            QUAL_NEUTRAL: ;
            QUAL_FAIL: begin
                if (!is_all || d == 0 || lv.all) begin
                    lv.res = RES_FAIL;
                end
            end
            default: lv.res = RES_PASS;
        endcase
        levels[d] = lv;
    endfunction

    function logic [2:0] flip_qual(logic [2:0] q);
        case (q)
            QUAL_PASS:     return QUAL_FAIL;
            QUAL_FAIL:     return QUAL_PASS;
            QUAL_SOFTFAIL: return QUAL_NEUTRAL;
            QUAL_NEUTRAL:  return QUAL_NEUTRAL;
            default:       return QUAL_NONE;
        endcase
    endfunction

    // A closed child level counts as a match of its begin entry
    function void fold_child(int unsigned d, logic [1:0] res, logic [2:0] q);
        logic [2:0] qq;
        if (res == RES_NONE) begin
            return;
        end
        qq = (res == RES_FAIL) ? flip_qual(q) : q;
        match_level(d, 1'b1, qq, 1'b0);
    endfunction

    function logic [1:0] exhausted_res(int unsigned d);
        level_t lv;
        lv = levels[d];
        return (lv.res == RES_NONE && lv.bias) ? RES_FAIL : lv.res;
    endfunction

    // Called for every accepted rule word
    function void note_rule(rule_t r);
        int unsigned d;
        logic [1:0]  res;
        logic [2:0]  q;
        level_t      lv;
        verdict_t    v;
        d = depth;
        if (!end_seen) begin
            if (d >= NEST_LEVELS) begin
                // levels that did not fit only move the count
                if (r.kind == KIND_BEGIN) begin
                    if (depth != 32'hffff_ffff) depth++;
                end else if (r.kind == KIND_END) begin
                    depth--;
                end
            end else begin
                case (r.kind)
                    KIND_ALL:    match_level(d, 1'b1, r.qual, 1'b1);
                    KIND_EXISTS: match_level(d, r.hit, r.qual, 1'b0);
                    KIND_IP4, KIND_IP6:
                        match_level(d, net_hit(r.net_hi, r.net_lo, r.plen), r.qual, 1'b0);
                    KIND_BEGIN: begin
                        if (d + 1 < NEST_LEVELS) begin
                            depth     = d + 1;
                            lv        = '0;
                            lv.all    = r.redir;
                            lv.qual   = r.qual;
                            levels[d + 1] = lv;
                        end else begin
                            nest_overflow = 1'b1;
                            depth         = NEST_LEVELS;
                        end
                    end
                    KIND_END: begin
                        if (d == 0) begin
                            end_seen = 1'b1;
                        end else begin
                            res   = levels[d].res;
                            q     = levels[d].qual;
                            depth = d - 1;
                            fold_child(d - 1, res, q);
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!r.last) begin
            return;
        end
        // unwind whatever is still open, unless the outer end froze the verdict
        if (end_seen) begin
            v.verdict = levels[0].res;
        end else begin
            d = (depth >= NEST_LEVELS) ? NEST_LEVELS - 1 : depth;
            while (d > 0) begin
                res = exhausted_res(d);
                q   = levels[d].qual;
                d--;
                fold_child(d, res, q);
            end
            v.verdict = exhausted_res(0);
        end
        v.overflow = nest_overflow;
        owed_verdicts.push_back(v);
        clear_list();
    endfunction

    // Called for every accepted verdict word
    function void check_word(logic [7:0] w);
        verdict_t v;
        if (owed_verdicts.size() == 0) begin
            $error("verdict word %h arrived with none expected", w);
            mismatches++;
            return;
        end
        v = owed_verdicts.pop_front();
        // tdata: verdict[1:0], overflow[2]
        if (w[1:0] !== v.verdict) begin
            $error("verdict: expected %0d, got %0d", v.verdict, w[1:0]);
            mismatches++;
        end
        if (w[2] !== v.overflow) begin
            $error("overflow: expected %0d, got %0d", v.overflow, w[2]);
            mismatches++;
        end
    endfunction
endclass

module spf_rule_table_evaluator_core_test;

    localparam logic [2:0] KIND_RSVD_A = 3'd6;
    localparam logic [2:0] KIND_RSVD_B = 3'd7;
    localparam logic [2:0] QUAL_TOP    = 3'd7;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int PHASES          = 6;
    localparam int LATENCY_WAIT    = NEST_LEVELS + 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int HANG_LIMIT      = 4000;
    localparam logic [63:0] DIR_HI = 64'h0;
    localparam logic [63:0] DIR_LO = 64'h0000_ffff_c0a8_0101;

    localparam int LIST_PLAIN = 0;
    localparam int LIST_DEEP  = 1;
    localparam int LIST_NOISE = 2;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [143:0]         s_tdata   = '0;
    logic [2:0]           s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;

    spf_verdict_board sb;
    bit               hold_req    = 1'b0;
    int               burst_left  = 0;
    int               rule_count  = 0;
    int               stall_cycles = 0;
    logic [63:0]      client_hi   = '0;
    logic [63:0]      client_lo   = '0;

    spf_rule_table_evaluator_core #(
        .MAX_NEST (NEST_LEVELS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
    end

    // Hang watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= HANG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: segments of varying readiness, plus a long hold-off on request
    initial begin
        int seg;
        int mode;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            for (int k = 0; k < seg && !hold_req; k++) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= k[2];
                endcase
                @(posedge aclk);
            end
        end
    end

    function automatic rule_t mk(logic [2:0] kind, logic [2:0] qual, logic hit, logic redir,
                                 logic [63:0] nh, logic [63:0] nl, logic [7:0] plen,
                                 logic last);
        rule_t r;
        r.kind   = kind;
        r.qual   = qual;
        r.hit    = hit;
        r.redir  = redir;
        r.net_hi = nh;
        r.net_lo = nl;
        r.plen   = plen;
        r.last   = last;
        return r;
    endfunction

    // Mostly valid qualifiers, sometimes the unused codes above neutral
    function automatic logic [2:0] rand_qual();
        if ($urandom_range(0, 9) == 0) begin
            return 3'($urandom_range(QUAL_NEUTRAL + 1, QUAL_TOP));
        end
        return 3'($urandom_range(QUAL_NONE, QUAL_NEUTRAL));
    endfunction

    // Network entry that hits or just misses the current client address
    function automatic rule_t net_rule(logic [2:0] kind, bit want_hit, bit last);
        rule_t        r;
        logic [127:0] mask;
        logic [127:0] addr;
        logic [127:0] noise;
        int           p;
        int           pe;
        int           b;
        if ($urandom_range(0, 9) == 0) begin
            p = $urandom_range(129, 255);
        end else if (kind == KIND_IP4) begin
            p = $urandom_range(96, 128);
        end else begin
            p = $urandom_range(0, 128);
        end
        pe    = (p > 128) ? 128 : p;
        mask  = ~({128{1'b1}} >> pe);
        noise = {$urandom, $urandom, $urandom, $urandom};
        addr  = {client_hi, client_lo} ^ (noise & ~mask);
        if (!want_hit && pe > 0) begin
            b       = $urandom_range(128 - pe, 127);
            addr[b] = ~addr[b];
        end
        r = mk(kind, rand_qual(), 1'b0, 1'b0, addr[127:64], addr[63:0], p[7:0], last);
        return r;
    endfunction

    function automatic rule_t match_rule(bit last);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            return mk(KIND_ALL, rand_qual(), 1'b0, 1'b0, '0, '0, '0, last);
        end else if (pick < 4) begin
            return mk(KIND_EXISTS, rand_qual(), 1'($urandom_range(0, 1)), 1'b0, '0, '0, '0,
                      last);
        end else if (pick < 7) begin
            return net_rule(KIND_IP4, 1'($urandom_range(0, 1)), last);
        end
        return net_rule(KIND_IP6, 1'($urandom_range(0, 1)), last);
    endfunction

    function automatic rule_t nest_rule(logic [2:0] kind, bit last);
        return mk(kind, rand_qual(), 1'b0, 1'($urandom_range(0, 1)), '0, '0, '0, last);
    endfunction

    // Send one rule word; the sender runs in bursts with random gaps between them
    task automatic send_rule(input rule_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, r.plen, r.net_lo, r.net_hi, r.redir, r.hit, r.qual};
        s_tuser  <= r.kind;
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        sb.note_rule(r);
        if (r.kind <= KIND_END) rule_count++;
    endtask

    // Write both halves of the client address; valid stays up between the two words
    task automatic program_client(input logic [63:0] hi, input logic [63:0] lo);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CLIENT_ADDR_HI;
        cfg_data  <= hi;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_client_reg(REG_CLIENT_ADDR_HI, hi);
        cfg_valid <= 1'b1;
        cfg_index <= REG_CLIENT_ADDR_LO;
        cfg_data  <= lo;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_client_reg(REG_CLIENT_ADDR_LO, lo);
        cfg_valid <= 1'b0;
        client_hi = hi;
        client_lo = lo;
    endtask

    // Stop sending until every owed verdict is back, then let any unwind finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic run_list(input int style);
        rule_t list[$];
        rule_t r;
        int    len;
        int    open_lvls;
        int    pick;
        int    nbeg;
        int    nend;
        bit    fin;
        case (style)
            LIST_DEEP: begin
                // open 12 to 20 levels, which may run past the stack, then close some of them again
                nbeg = $urandom_range(12, 20);
                for (int i = 0; i < nbeg; i++) begin
                    if ($urandom_range(0, 2) == 0) list.push_back(match_rule(1'b0));
                    list.push_back(nest_rule(KIND_BEGIN, 1'b0));
                end
                nend = $urandom_range(0, nbeg + 2);
                for (int i = 0; i < nend; i++) begin
                    if ($urandom_range(0, 2) == 0) list.push_back(match_rule(1'b0));
                    list.push_back(nest_rule(KIND_END, 1'b0));
                end
                list.push_back(match_rule(1'b1));
            end
            LIST_NOISE: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    r.kind   = 3'($urandom_range(0, 7));
                    r.qual   = 3'($urandom_range(0, 7));
                    r.hit    = 1'($urandom_range(0, 1));
                    r.redir  = 1'($urandom_range(0, 1));
                    r.net_hi = {$urandom, $urandom};
                    r.net_lo = {$urandom, $urandom};
                    r.plen   = 8'($urandom_range(0, 255));
                    r.last   = (i == len - 1);
                    list.push_back(r);
                end
            end
            default: begin
                // nesting with random matches; an end may close the outermost level; open levels may run out
                len       = $urandom_range(1, 10);
                open_lvls = 0;
                for (int i = 0; i < len; i++) begin
                    fin  = (i == len - 1);
                    pick = $urandom_range(0, 99);
                    if (pick < 18 && open_lvls < 6) begin
                        list.push_back(nest_rule(KIND_BEGIN, fin));
                        open_lvls++;
                    end else if (pick < 34 && (open_lvls > 0 || pick >= 32)) begin
                        // at depth zero this closes the outermost level
                        list.push_back(nest_rule(KIND_END, fin));
                        if (open_lvls > 0) open_lvls--;
                    end else begin
                        list.push_back(match_rule(fin));
                    end
                end
            end
        endcase
        foreach (list[i]) send_rule(list[i]);
    endtask

    // Stimulus
    initial begin
        logic [63:0] hi;
        logic [63:0] lo;
        int          target;
        int          mid;
        int          pick;
        bit          pressed;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_client(DIR_HI, DIR_LO);

        // prefix above 128 acts as 128; mapped IPv4 /24 with no qualifier passes
        send_rule(mk(KIND_IP6, QUAL_PASS, 0, 0, DIR_HI, DIR_LO ^ 64'h1, 8'd255, 0));
        send_rule(mk(KIND_IP4, QUAL_NONE, 0, 0, DIR_HI, DIR_LO & 64'hffff_ffff_ffff_ff00,
                     8'd120, 1));
        // fail on all inside a plain include is dropped; outer softfail fails by exhaustion
        send_rule(mk(KIND_BEGIN, QUAL_PASS, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_ALL, QUAL_FAIL, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_END, QUAL_NONE, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_ALL, QUAL_SOFTFAIL, 0, 0, '0, '0, '0, 1));
        // under a redirect the all fails; pass on the begin inverts to fail
        send_rule(mk(KIND_BEGIN, QUAL_PASS, 0, 1, '0, '0, '0, 0));
        send_rule(mk(KIND_ALL, QUAL_FAIL, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_END, QUAL_NONE, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_EXISTS, QUAL_NEUTRAL, 1, 0, '0, '0, '0, 1));
        // child fail under a fail begin turns into pass
        send_rule(mk(KIND_BEGIN, QUAL_FAIL, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_EXISTS, QUAL_FAIL, 1, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_END, QUAL_NONE, 0, 0, '0, '0, '0, 1));
        // outermost end freezes the verdict, softfail bias is not converted
        send_rule(mk(KIND_EXISTS, QUAL_SOFTFAIL, 1, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_END, QUAL_NONE, 0, 0, '0, '0, '0, 0));
        send_rule(mk(KIND_IP6, QUAL_PASS, 0, 0, DIR_HI, DIR_LO, 8'd128, 1));
        // unused kinds; zero prefix matches an all-ones network
        send_rule(mk(KIND_RSVD_A, QUAL_PASS, 1, 1, '1, '1, '1, 0));
        send_rule(mk(KIND_IP6, QUAL_FAIL, 0, 0, '1, '1, 8'd0, 0));
        send_rule(mk(KIND_RSVD_B, QUAL_PASS, 0, 0, '0, '0, '0, 1));
        // one begin more than the stack holds
        for (int i = 0; i < NEST_LEVELS; i++) begin
            send_rule(mk(KIND_BEGIN, i[0] ? QUAL_FAIL : QUAL_PASS, 0, i[0], '0, '0, '0,
                         i == NEST_LEVELS - 1));
        end
        settle();

        // Random phases, each under its own client address
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin hi = '0; lo = '0; end
                1: begin hi = '1; lo = '1; end
                2, 4: begin hi = '0; lo = {16'h0000, 16'hffff, 32'($urandom)}; end
                3: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
                default: begin hi = 64'h8000_0000_0000_0000; lo = 64'h1; end
            endcase
            program_client(hi, lo);
            target  = rule_count + ITEMS_PER_PHASE;
            mid     = rule_count + ITEMS_PER_PHASE / 2;
            pressed = 1'b0;
            while (rule_count < target) begin
                if (!pressed && rule_count >= mid) begin
                    pressed = 1'b1;
                    if (phase % 2 == 1) begin
                        hold_req = 1'b1;
                    end else if (phase == 2) begin
                        settle();
                    end
                end
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    run_list(LIST_DEEP);
                end else if (pick < 14) begin
                    run_list(LIST_NOISE);
                end else begin
                    run_list(LIST_PLAIN);
                end
            end
            settle();
        end

        repeat (LATENCY_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
design/srte_pkg.sv
design/srte_front.sv
design/srte_queue.sv
design/srte_back.sv
design/spf_rule_table_evaluator_core.sv
tb/sv/spf_rule_table_evaluator_core_test.sv
